// ===== hdl/thr_pkg.sv =====
package thr_pkg;

    // Table entry fields
    localparam int RAW_W = 10;
    localparam int CEL_W = 9;
    localparam int ENTRY_W = RAW_W + CEL_W;

    // Interpolation quotient: |num| <= 1023*511 fits 19 bits, divisor 10 bits
    localparam int NUM_W = 19;
    localparam int DEN_W = 10;
    localparam int DIV_STEPS = NUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Signed sum of base celsius and quotient
    localparam int SUM_W = 21;

    // Result range of celsius
    localparam int OUT_CEL_W = 10;
    localparam int CEL_CLAMP_HI = 255;
    localparam int CEL_CLAMP_LO = -512;

    // floor(t*11/10) == (t * UPPER_MUL) >> UPPER_SHIFT for t in 0..255
    localparam int UPPER_MUL = 72094;
    localparam int UPPER_SHIFT = 16;
    localparam int UPPER_PROD_W = 25;
    localparam int UPPER_W = 9;

    typedef enum logic [1:0] {
        BAND_HIGH = 2'd0,
        BAND_LOW  = 2'd1,
        BAND_OFF  = 2'd2
    } band_t;

    // Controller -> datapath
    typedef struct packed {
        logic start;      // sample beat taken: latch sample and count, rewind index
        logic tbl_write;  // table write beat taken
        logic prev_load;  // current entry becomes the previous one
        logic idx_step;   // advance the scan index
        logic set_past;   // sample beyond the table
        logic setup;      // form numerator and divisor magnitudes
        logic div_step;   // one restoring division step
        logic fix;        // add quotient, clamp
        logic load_out;   // load result register
    } thr_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic short_tbl;  // fewer than two entries in use
        logic hit;        // current entry raw exceeds the sample
        logic last;       // current entry is the last in use
        logic div_last;   // final division step
    } thr_status_t;

endpackage

// ===== hdl/thr_ram.sv =====
module thr_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hdl/thr_ctrl.sv =====
module thr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  logic                 req_type,
    output logic                 req_ready,
    output logic                 res_valid,
    input  logic                 res_ready,
    input  thr_pkg::thr_status_t status,
    output thr_pkg::thr_cmd_t    cmd
);

    typedef enum logic [2:0] {
        IDLE,
        FIRST,
        SCAN,
        SETUP,
        DIV,
        FIX,
        RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   res_valid_reg;
    logic   res_valid_next;

    assign req_ready = (state_reg == IDLE);
    assign res_valid = res_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        res_valid_next = res_valid_reg && !res_ready;
        cmd = '0;
        unique case (state_reg)
            IDLE:
            begin
                if (req_valid)
                begin
                    if (req_type)
                    begin
                        cmd.tbl_write = 1'b1;
                    end
                    else
                    begin
                        cmd.start = 1'b1;
                        state_next = FIRST;
                    end
                end
            end
            FIRST:
            begin
                if (status.short_tbl)
                begin
                    cmd.set_past = 1'b1;
                    state_next = RESULT;
                end
                else
                begin
                    cmd.prev_load = 1'b1;
                    cmd.idx_step = 1'b1;
                    state_next = SCAN;
                end
            end
            SCAN:
            begin
                priority if (status.hit)
                begin
                    state_next = SETUP;
                end
                else if (status.last)
                begin
                    cmd.set_past = 1'b1;
                    state_next = RESULT;
                end
                else
                begin
                    cmd.prev_load = 1'b1;
                    cmd.idx_step = 1'b1;
                end
            end
            SETUP:
            begin
                cmd.setup = 1'b1;
                state_next = DIV;
            end
            DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = FIX;
                end
            end
            FIX:
            begin
                cmd.fix = 1'b1;
                state_next = RESULT;
            end
            RESULT:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    cmd.load_out = 1'b1;
                    res_valid_next = 1'b1;
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_sample_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && !req_type) |=> !req_ready)
        else $error("sample beat did not close the input");

    a_write_keeps_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && req_type) |=> req_ready)
        else $error("table write stalled the input");

    a_result_from_result_state: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !$past(res_valid_reg)) |-> $past(cmd.load_out))
        else $error("result raised without a load");
`endif

endmodule

// ===== hdl/thr_dp.sv =====
module thr_dp #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  thr_pkg::thr_cmd_t    cmd,
    output thr_pkg::thr_status_t status,
    input  logic [9:0]           raw_sample,
    input  logic [4:0]           point_index,
    input  logic [9:0]           point_raw,
    input  logic [8:0]           point_celsius,
    input  logic [7:0]           target_temp,
    input  logic [7:0]           heater_high_pwm,
    input  logic [7:0]           heater_low_pwm,
    input  logic [5:0]           entries_in_use,
    output logic [9:0]           celsius,
    output logic [7:0]           heater_duty,
    output logic [1:0]           heater_band,
    output logic                 past_table
);

    localparam int AW = $clog2(TABLE_DEPTH);

    // Table memory
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [thr_pkg::ENTRY_W-1:0]   wr_data;
    logic [thr_pkg::ENTRY_W-1:0]   rd_data;
    logic [thr_pkg::RAW_W-1:0]     rd_raw;
    logic [thr_pkg::CEL_W-1:0]     rd_cel;

    // Scan
    logic [AW-1:0]                 idx_reg;
    logic [AW-1:0]                 idx_next;
    logic [AW-1:0]                 last_reg;
    logic                          short_reg;
    logic [thr_pkg::RAW_W-1:0]     raw_reg;
    logic [thr_pkg::RAW_W-1:0]     prev_raw_reg;
    logic [thr_pkg::CEL_W-1:0]     prev_cel_reg;
    int                            n_use;

    // Interpolation
    logic signed [10:0]            dr;
    logic signed [9:0]             dc;
    logic signed [10:0]            den;
    logic signed [20:0]            prod;
    logic [20:0]                   prod_abs;
    logic [10:0]                   den_abs;
    logic [thr_pkg::NUM_W-1:0]     quo_reg;
    logic [thr_pkg::DEN_W-1:0]     rem_reg;
    logic [thr_pkg::DEN_W-1:0]     den_mag_reg;
    logic                          neg_reg;
    logic                          den_zero_reg;
    logic [thr_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [thr_pkg::DEN_W:0]       shifted;
    logic [thr_pkg::DEN_W+1:0]     diff;
    logic signed [thr_pkg::SUM_W-1:0] q_signed;
    logic signed [thr_pkg::SUM_W-1:0] sum;
    logic [thr_pkg::OUT_CEL_W-1:0] cel_clamped;

    // Result
    logic [thr_pkg::OUT_CEL_W-1:0] cel_reg;
    logic                          past_reg;
    logic [thr_pkg::UPPER_PROD_W-1:0] upper_prod;
    logic [thr_pkg::UPPER_W-1:0]   upper_reg;
    logic signed [10:0]            cel_ext;
    logic signed [10:0]            tgt_ext;
    logic signed [10:0]            upper_ext;
    thr_pkg::band_t                band_next;
    logic [7:0]                    duty_next;
    logic [thr_pkg::OUT_CEL_W-1:0] out_cel_reg;
    logic [7:0]                    out_duty_reg;
    thr_pkg::band_t                out_band_reg;
    logic                          out_past_reg;

    assign wr_en   = cmd.tbl_write && (int'(point_index) < TABLE_DEPTH);
    assign wr_addr = AW'(point_index);
    assign wr_data = {point_raw, point_celsius};

    thr_ram #(
        .WIDTH(thr_pkg::ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(idx_next),
        .rd_data(rd_data)
    );

    assign rd_raw = rd_data[thr_pkg::ENTRY_W-1:thr_pkg::CEL_W];
    assign rd_cel = rd_data[thr_pkg::CEL_W-1:0];

    // Read address is the next index, so the registered read data lines up with idx_reg
    always_comb
    begin
        priority if (cmd.start)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_step)
        begin
            idx_next = idx_reg + AW'(1);
        end
        else
        begin
            idx_next = idx_reg;
        end
    end

    assign n_use = (int'(entries_in_use) > TABLE_DEPTH) ? TABLE_DEPTH : int'(entries_in_use);

    assign status.short_tbl = short_reg;
    assign status.hit       = rd_raw > raw_reg;
    assign status.last      = idx_reg == last_reg;
    assign status.div_last  = div_cnt_reg == thr_pkg::DIV_CNT_W'(thr_pkg::DIV_STEPS - 1);

    // Differences against the previous entry; rd_data still holds the hit entry
    assign dr   = $signed({1'b0, raw_reg}) - $signed({1'b0, prev_raw_reg});
    assign dc   = $signed({1'b0, rd_cel}) - $signed({1'b0, prev_cel_reg});
    assign den  = $signed({1'b0, rd_raw}) - $signed({1'b0, prev_raw_reg});
    assign prod = 21'(dr) * 21'(dc);
    assign prod_abs = prod[20] ? 21'(-prod) : 21'(prod);
    assign den_abs  = den[10] ? 11'(-den) : 11'(den);

    // Restoring division, one quotient bit a cycle
    assign shifted = {rem_reg, quo_reg[thr_pkg::NUM_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, den_mag_reg};

    always_comb
    begin
        q_signed = den_zero_reg ? '0 : thr_pkg::SUM_W'({2'b00, quo_reg});
        if (neg_reg)
        begin
            q_signed = -q_signed;
        end
        sum = thr_pkg::SUM_W'({12'd0, prev_cel_reg}) + q_signed;
        priority if (sum > thr_pkg::SUM_W'(thr_pkg::CEL_CLAMP_HI))
        begin
            cel_clamped = thr_pkg::OUT_CEL_W'(thr_pkg::CEL_CLAMP_HI);
        end
        else if (sum < thr_pkg::SUM_W'(thr_pkg::CEL_CLAMP_LO))
        begin
            cel_clamped = thr_pkg::OUT_CEL_W'(thr_pkg::CEL_CLAMP_LO);
        end
        else
        begin
            cel_clamped = sum[thr_pkg::OUT_CEL_W-1:0];
        end
    end

    // Heater band
    assign upper_prod = thr_pkg::UPPER_PROD_W'(target_temp)
                      * thr_pkg::UPPER_PROD_W'(thr_pkg::UPPER_MUL);
    assign cel_ext   = {cel_reg[thr_pkg::OUT_CEL_W-1], cel_reg};
    assign tgt_ext   = $signed({3'b000, target_temp});
    assign upper_ext = $signed({2'b00, upper_reg});

    always_comb
    begin
        priority if (cel_ext < tgt_ext)
        begin
            band_next = thr_pkg::BAND_HIGH;
            duty_next = heater_high_pwm;
        end
        else if (cel_ext < upper_ext)
        begin
            band_next = thr_pkg::BAND_LOW;
            duty_next = heater_low_pwm;
        end
        else
        begin
            band_next = thr_pkg::BAND_OFF;
            duty_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            div_cnt_reg <= '0;
            upper_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            upper_reg <= upper_prod[thr_pkg::UPPER_SHIFT +: thr_pkg::UPPER_W];
            if (cmd.setup)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + thr_pkg::DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            raw_reg <= raw_sample;
            short_reg <= entries_in_use < 6'd2;
            last_reg <= AW'(n_use - 1);
            past_reg <= 1'b0;
        end
        if (cmd.prev_load)
        begin
            prev_raw_reg <= rd_raw;
            prev_cel_reg <= rd_cel;
        end
        if (cmd.setup)
        begin
            quo_reg <= prod_abs[thr_pkg::NUM_W-1:0];
            rem_reg <= '0;
            den_mag_reg <= den_abs[thr_pkg::DEN_W-1:0];
            neg_reg <= prod[20] ^ den[10];
            den_zero_reg <= den == 11'sd0;
        end
        if (cmd.div_step)
        begin
            if (!diff[thr_pkg::DEN_W+1])
            begin
                rem_reg <= diff[thr_pkg::DEN_W-1:0];
                quo_reg <= {quo_reg[thr_pkg::NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[thr_pkg::DEN_W-1:0];
                quo_reg <= {quo_reg[thr_pkg::NUM_W-2:0], 1'b0};
            end
        end
        if (cmd.set_past)
        begin
            past_reg <= 1'b1;
            cel_reg <= '0;
        end
        if (cmd.fix)
        begin
            cel_reg <= cel_clamped;
        end
        if (cmd.load_out)
        begin
            out_cel_reg <= cel_reg;
            out_duty_reg <= duty_next;
            out_band_reg <= band_next;
            out_past_reg <= past_reg;
        end
    end

    assign celsius     = out_cel_reg;
    assign heater_duty = out_duty_reg;
    assign heater_band = out_band_reg;
    assign past_table  = out_past_reg;

`ifndef SYNTHESIS
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.idx_step && !cmd.start && $past(cmd.prev_load) && !$past(cmd.start))
            |-> idx_reg != last_reg)
        else $error("scan stepped past the last entry in use");

    a_div_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |=> (div_cnt_reg != '0) || $past(status.div_last))
        else $error("division counter wrapped early");
`endif

endmodule

// ===== hdl/thermistor_heater_regulator.sv =====
// Thermistor table interpolation with a three-level heater regulator.
//
// Input channel (req_valid/req_ready): a beat with req_type 1 writes one
// (point_raw, point_celsius) pair into the table at point_index and gives no
// result; indexes at or above TABLE_DEPTH are dropped. A beat with req_type 0
// converts raw_sample and gives exactly one result beat on the output channel
// (res_valid/res_ready): celsius, heater_duty, heater_band, past_table.
// Table writes are taken one per cycle while no sample is in progress. A
// sample scans the table one entry a cycle through the single read port of
// the table RAM, then runs the restoring divider once it finds the first
// entry whose raw value exceeds the sample; a sample past the entries in use,
// or with fewer than two in use, goes straight to the result. The input is
// ready again in the cycle the result appears. The result sits in an output
// register; a stalled receiver holds it there while the next sample is taken
// and worked on, and that sample waits for the register to free. Configuration
// sits on an APB port; the user must write it only while idle, the block does
// not enforce this. Reset clears control and sets the registers to their
// defaults (entries 32); table contents are undefined until written.
module thermistor_heater_regulator #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,

    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // Input beats
    input  logic        req_valid,
    output logic        req_ready,
    input  logic        req_type,
    input  logic [9:0]  raw_sample,
    input  logic [4:0]  point_index,
    input  logic [9:0]  point_raw,
    input  logic [8:0]  point_celsius,

    // Result beats
    output logic        res_valid,
    input  logic        res_ready,
    output logic [9:0]  celsius,
    output logic [7:0]  heater_duty,
    output logic [1:0]  heater_band,
    output logic        past_table
);

    typedef enum logic [1:0] {
        REG_TARGET  = 2'd0,
        REG_HIGH    = 2'd1,
        REG_LOW     = 2'd2,
        REG_ENTRIES = 2'd3
    } reg_index_t;

    localparam logic [5:0] ENTRIES_RESET = 6'd32;

    logic [7:0] target_reg;
    logic [7:0] high_pwm_reg;
    logic [7:0] low_pwm_reg;
    logic [5:0] entries_reg;
    logic       apb_write;
    reg_index_t reg_index;

    thr_pkg::thr_cmd_t    cmd;
    thr_pkg::thr_status_t status;

    assign pready    = 1'b1;
    assign apb_write = psel && penable && pwrite;
    assign reg_index = reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            high_pwm_reg <= '0;
            low_pwm_reg <= '0;
            entries_reg <= ENTRIES_RESET;
        end
        else if (apb_write)
        begin
            unique case (reg_index)
                REG_TARGET:  target_reg <= pwdata[7:0];
                REG_HIGH:    high_pwm_reg <= pwdata[7:0];
                REG_LOW:     low_pwm_reg <= pwdata[7:0];
                REG_ENTRIES: entries_reg <= pwdata[5:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_TARGET:  prdata = {24'd0, target_reg};
            REG_HIGH:    prdata = {24'd0, high_pwm_reg};
            REG_LOW:     prdata = {24'd0, low_pwm_reg};
            REG_ENTRIES: prdata = {26'd0, entries_reg};
            default:     prdata = '0;
        endcase
    end

    // Sequencer: scan, divide, clamp, band select, result handshake
    thr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_type (req_type),
        .req_ready(req_ready),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Table RAM, interpolation arithmetic, result register
    thr_dp #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .raw_sample     (raw_sample),
        .point_index    (point_index),
        .point_raw      (point_raw),
        .point_celsius  (point_celsius),
        .target_temp    (target_reg),
        .heater_high_pwm(high_pwm_reg),
        .heater_low_pwm (low_pwm_reg),
        .entries_in_use (entries_reg),
        .celsius        (celsius),
        .heater_duty    (heater_duty),
        .heater_band    (heater_band),
        .past_table     (past_table)
    );

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 32;
    localparam int CLK_HALF = 4;
    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_ITEMS = 800;
    localparam int CALM_TAIL = 100;        // items at the end sent with no idling
    localparam int SETTLE_CYCLES = 64;     // quiet wait, longer than the slowest sample
    localparam int HOLD_OFF_CYCLES = 300;  // long receiver stall, fills the block
    localparam int RUN_LIMIT_NS = 8_000_000;

    // Request kinds
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_POINT = 1'b1;

    // Register indexes, byte address is 4*index
    localparam int REG_TARGET = 0;
    localparam int REG_HIGH_PWM = 1;
    localparam int REG_LOW_PWM = 2;
    localparam int REG_ENTRIES = 3;

    // Samples around the band edges for target 100 on the linear table
    // (celsius = (raw-8)/2): 99, 100, 109, 110, then clamp, past-table and low in-table cases.
    localparam int BAND_EDGE_SAMPLES [10] = '{206, 208, 226, 228, 600, 999, 1000, 1023,
                                               8, 40};

    typedef struct {
        logic                      kind;
        logic [thr_pkg::RAW_W-1:0] sample;
        logic [4:0]                idx;
        logic [thr_pkg::RAW_W-1:0] praw;
        logic [thr_pkg::CEL_W-1:0] pcel;
    } sensor_req_t;

    typedef struct {
        logic [thr_pkg::OUT_CEL_W-1:0] celsius;
        logic [7:0]                    duty;
        thr_pkg::band_t                band;
        logic                          past;
    } heater_reading_t;

    // Clock, reset and APB, all known from time zero
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Input channel
    logic                      req_valid = 1'b0;
    logic                      req_ready;
    logic                      req_type = REQ_SAMPLE;
    logic [thr_pkg::RAW_W-1:0] raw_sample = '0;
    logic [4:0]                point_index = '0;
    logic [thr_pkg::RAW_W-1:0] point_raw = '0;
    logic [thr_pkg::CEL_W-1:0] point_celsius = '0;

    // Result channel
    logic                          res_valid;
    logic                          res_ready = 1'b0;
    logic [thr_pkg::OUT_CEL_W-1:0] celsius;
    logic [7:0]                    heater_duty;
    logic [1:0]                    heater_band;
    logic                          past_table;

    // Stimulus plumbing
    sensor_req_t     req_queue[$];
    heater_reading_t expected_readings[$];
    logic            req_fire = 1'b0;   // input beat taken at the last rising edge
    int              send_gap = 0;
    int              ready_gap = 0;
    int              hold_left = 0;
    bit              calm = 1'b0;       // no idling on either side
    bit              long_hold_arm = 1'b0;
    bit              long_hold_done = 1'b0;

    // Shadow copy of the block: registers and thermistor table
    logic [7:0]                target_cfg = 8'd0;
    logic [7:0]                high_pwm_cfg = 8'd0;
    logic [7:0]                low_pwm_cfg = 8'd0;
    logic [5:0]                entries_cfg = 6'd32;
    logic [thr_pkg::RAW_W-1:0] cal_raw [TABLE_DEPTH];
    logic [thr_pkg::CEL_W-1:0] cal_cel [TABLE_DEPTH];

    // Generator's view of the raw column, used to aim samples at the table
    int gen_raw [TABLE_DEPTH];

    // Bookkeeping
    int mismatches = 0;
    int items_queued = 0;
    int points_taken = 0;
    int samples_taken = 0;
    int results_checked = 0;
    int past_seen = 0;
    int reg_writes = 0;

    thermistor_heater_regulator #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req_type(req_type),
        .raw_sample(raw_sample),
        .point_index(point_index),
        .point_raw(point_raw),
        .point_celsius(point_celsius),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .celsius(celsius),
        .heater_duty(heater_duty),
        .heater_band(heater_band),
        .past_table(past_table)
    );

    always #CLK_HALF clk = ~clk;

    // Expected reading for one sample. Scan from entry 1 for the first raw value
    // above the sample, interpolate from the entry before it in signed 32-bit
    // arithmetic (quotient truncates toward zero, zero divisor adds nothing),
    // clamp to the output range, then pick the heater band.
    function automatic heater_reading_t predict_reading(
        input logic [thr_pkg::RAW_W-1:0] sample
    );
        heater_reading_t rd;
        int  span;
        int  r0;
        int  r1;
        int  c0;
        int  c1;
        int  den;
        int  num;
        int  cel;
        int  tgt;
        int  upper;
        bit  hit;
        span = (entries_cfg > TABLE_DEPTH) ? TABLE_DEPTH : int'(entries_cfg);
        cel = 0;
        hit = 1'b0;
        for (int i = 1; i < span; i++)
        begin
            if (!hit && int'(cal_raw[i]) > int'(sample))
            begin
                hit = 1'b1;
                r0 = int'(cal_raw[i-1]);
                r1 = int'(cal_raw[i]);
                c0 = int'(cal_cel[i-1]);
                c1 = int'(cal_cel[i]);
                den = r1 - r0;
                num = (int'(sample) - r0) * (c1 - c0);
                cel = c0 + ((den != 0) ? num / den : 0);
                if (cel > thr_pkg::CEL_CLAMP_HI)
                    cel = thr_pkg::CEL_CLAMP_HI;
                if (cel < thr_pkg::CEL_CLAMP_LO)
                    cel = thr_pkg::CEL_CLAMP_LO;
            end
        end
        rd.celsius = thr_pkg::OUT_CEL_W'(cel);
        rd.past = !hit;
        tgt = int'(target_cfg);
        upper = (tgt * 11) / 10;
        if (cel < tgt)
        begin
            rd.duty = high_pwm_cfg;
            rd.band = thr_pkg::BAND_HIGH;
        end
        else if (cel < upper)
        begin
            rd.duty = low_pwm_cfg;
            rd.band = thr_pkg::BAND_LOW;
        end
        else
        begin
            rd.duty = 8'd0;
            rd.band = thr_pkg::BAND_OFF;
        end
        return rd;
    endfunction

    // Sender: a new beat goes out only once the previous one has been taken.
    // Random idle bursts fall between beats unless the run is calm.
    always @(negedge clk)
    begin
        sensor_req_t nxt;
        if (rst_n && !(req_valid && !req_fire))
        begin
            if (send_gap > 0)
            begin
                req_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                req_valid <= 1'b0;
                send_gap <= $urandom_range(0, 5);
            end
            else if (req_queue.size() > 0)
            begin
                nxt = req_queue.pop_front();
                req_valid <= 1'b1;
                req_type <= nxt.kind;
                raw_sample <= nxt.sample;
                point_index <= nxt.idx;
                point_raw <= nxt.praw;
                point_celsius <= nxt.pcel;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Receiver: random stall bursts, plus one long hold-off so that the result
    // register and the working sample both back up and the input stalls.
    always @(negedge clk)
    begin
        if (!rst_n)
            res_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            res_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (long_hold_arm && !long_hold_done)
        begin
            res_ready <= 1'b0;
            hold_left <= HOLD_OFF_CYCLES - 1;
            long_hold_done <= 1'b1;
        end
        else if (ready_gap > 0)
        begin
            res_ready <= 1'b0;
            ready_gap <= ready_gap - 1;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            res_ready <= 1'b0;
            ready_gap <= $urandom_range(0, 5);
        end
        else
            res_ready <= 1'b1;
    end

    // Monitor: check each result beat against the oldest expectation, then
    // apply the input beat taken at this edge to the shadow model.
    always @(posedge clk)
    begin
        heater_reading_t want;
        req_fire <= rst_n && req_valid && req_ready;
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                if (expected_readings.size() == 0)
                begin
                    $error("result beat with nothing expected: celsius %0d",
                           $signed(celsius));
                    mismatches++;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    results_checked++;
                    if (celsius !== want.celsius)
                    begin
                        $error("celsius: expected %0d, got %0d",
                               $signed(want.celsius), $signed(celsius));
                        mismatches++;
                    end
                    if (heater_duty !== want.duty)
                    begin
                        $error("heater_duty: expected %0d, got %0d", want.duty, heater_duty);
                        mismatches++;
                    end
                    if (heater_band !== want.band)
                    begin
                        $error("heater_band: expected %0d, got %0d", want.band, heater_band);
                        mismatches++;
                    end
                    if (past_table !== want.past)
                    begin
                        $error("past_table: expected %0d, got %0d", want.past, past_table);
                        mismatches++;
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                if (req_type == REQ_POINT)
                begin
                    cal_raw[point_index] = point_raw;
                    cal_cel[point_index] = point_celsius;
                    points_taken++;
                end
                else
                begin
                    want = predict_reading(raw_sample);
                    expected_readings.push_back(want);
                    samples_taken++;
                    if (want.past)
                        past_seen++;
                end
            end
        end
    end

    // Table point write; the sample field carries junk
    task automatic queue_point(input int idx, input int rawv, input int celv);
        sensor_req_t it;
        it.kind = REQ_POINT;
        it.sample = thr_pkg::RAW_W'($urandom);
        it.idx = 5'(idx);
        it.praw = thr_pkg::RAW_W'(rawv);
        it.pcel = thr_pkg::CEL_W'(celv);
        req_queue.push_back(it);
        gen_raw[idx] = rawv;
        items_queued++;
    endtask

    // Temperature sample; the point fields carry junk
    task automatic queue_sample(input int rawv);
        sensor_req_t it;
        it.kind = REQ_SAMPLE;
        it.sample = thr_pkg::RAW_W'(rawv);
        it.idx = 5'($urandom);
        it.praw = thr_pkg::RAW_W'($urandom);
        it.pcel = thr_pkg::CEL_W'($urandom);
        req_queue.push_back(it);
        items_queued++;
    endtask

    // APB write: setup, access, then release. Upper data bits carry junk.
    task automatic write_reg(input int idx, input int value, input int width);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = 4'(idx * 4);
        pwdata = ($urandom << width) | 32'(value);
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            REG_TARGET:   target_cfg = 8'(value);
            REG_HIGH_PWM: high_pwm_cfg = 8'(value);
            REG_LOW_PWM:  low_pwm_cfg = 8'(value);
            REG_ENTRIES:  entries_cfg = 6'(value);
            default:      ;
        endcase
        reg_writes++;
    endtask

    task automatic apply_config(input int tgt, input int hi, input int lo, input int n);
        write_reg(REG_TARGET, tgt, 8);
        write_reg(REG_HIGH_PWM, hi, 8);
        write_reg(REG_LOW_PWM, lo, 8);
        write_reg(REG_ENTRIES, n, 6);
    endtask

    // Sender pauses here until every queued beat is taken and every expected
    // result has come back; table writes give no result, so allow the worst
    // latency on top before touching the registers.
    task automatic wait_quiet();
        while (req_queue.size() != 0 || req_valid || expected_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int  directed_items;
        int  phase;
        int  n;
        int  last;
        int  span_hi;
        int  r;
        int  c;
        int  max_step;
        int  pick;
        int  kind;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Directed: load a linear table (celsius = (raw-8)/2) before any sample so
        // that no entry is ever read unwritten, then sample with reset defaults.
        for (int i = 0; i < TABLE_DEPTH; i++)
            queue_point(i, 32 * i + 8, 16 * i);
        queue_sample(300);
        queue_sample(0);        // below entry 0: negative, under target 0
        wait_quiet();

        // Band edges, top clamp, exact hit on the last entry, past table
        apply_config(100, 200, 50, 32);
        foreach (BAND_EDGE_SAMPLES[k])
            queue_sample(BAND_EDGE_SAMPLES[k]);
        // Equal raw values in adjacent entries: zero divisor, previous celsius
        queue_point(0, 8, 20);
        queue_point(1, 8, 300);
        queue_sample(5);
        // Non-monotone pair with a steep slope: saturate low, then clamp high
        queue_point(0, 1000, 0);
        queue_point(1, 1001, 511);
        queue_sample(0);
        queue_point(0, 1000, 511);
        queue_point(1, 1001, 0);
        queue_sample(0);
        queue_sample(1000);
        wait_quiet();

        // One entry in use: nothing scanned, past table, full duties
        apply_config(255, 255, 255, 1);
        queue_sample(300);
        wait_quiet();
        // No entries, target 0: past table lands in the off band
        apply_config(0, 0, 255, 0);
        queue_sample(500);
        wait_quiet();
        // Count beyond the depth is capped
        apply_config(50, 128, 64, 63);
        queue_point(0, 8, 0);
        queue_point(1, 40, 16);
        queue_sample(1023);
        queue_sample(990);
        wait_quiet();
        // Smallest legal table
        apply_config(50, 128, 64, 2);
        queue_sample(20);
        queue_sample(40);
        directed_items = items_queued;

        // Random phases: fresh registers each time, mostly ordered tables with
        // random content, some scrambled tables and stray point writes.
        phase = 0;
        while (items_queued < directed_items + RANDOM_ITEMS)
        begin
            wait_quiet();
            if (items_queued >= directed_items + RANDOM_ITEMS - CALM_TAIL)
                calm = 1'b1;
            else
                calm = ($urandom_range(0, 3) == 0);

            case ($urandom_range(0, 5))
                0:       c = 0;
                1:       c = 255;
                default: c = $urandom_range(0, 255);
            endcase
            case ($urandom_range(0, 9))
                0:       n = $urandom_range(0, 1);
                1:       n = $urandom_range(33, 63);
                2:       n = 2;
                3:       n = 32;
                default: n = $urandom_range(2, 32);
            endcase
            apply_config(c, $urandom_range(0, 255), $urandom_range(0, 255), n);

            kind = $urandom_range(0, 9);
            if (kind <= 5)
            begin
                // Ordered raw column, occasional repeats; celsius falling as an
                // NTC part would give
                max_step = $urandom_range(1, 70);
                r = $urandom_range(0, 40);
                c = $urandom_range(300, 511);
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    queue_point(i, r, c);
                    r += ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, max_step);
                    if (r > 1023)
                        r = 1023;
                    c -= $urandom_range(0, 20);
                    if (c < 0)
                        c = 0;
                end
            end
            else if (kind <= 7)
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                    queue_point(i, $urandom_range(0, 1023), $urandom_range(0, 511));
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    queue_point($urandom_range(0, 31), $urandom_range(0, 1023),
                                $urandom_range(0, 511));
            end

            last = ((entries_cfg > TABLE_DEPTH) ? TABLE_DEPTH : int'(entries_cfg)) - 1;
            if (last < 0)
                last = 0;
            span_hi = 0;
            for (int i = 0; i <= last; i++)
                if (gen_raw[i] > span_hi)
                    span_hi = gen_raw[i];
            span_hi = (span_hi + 8 > 1023) ? 1023 : span_hi + 8;

            repeat ($urandom_range(20, 50))
            begin
                if ($urandom_range(0, 15) == 0)
                    queue_point($urandom_range(0, 31), $urandom_range(0, 1023),
                                $urandom_range(0, 511));
                pick = $urandom_range(0, 9);
                if (pick <= 1)
                    queue_sample($urandom_range(0, 1023));
                else if (pick <= 4)
                begin
                    // just below, on, or just above a table point
                    r = gen_raw[$urandom_range(0, last)] + $urandom_range(0, 2) - 1;
                    queue_sample((r < 0) ? 0 : ((r > 1023) ? 1023 : r));
                end
                else
                    queue_sample($urandom_range(0, span_hi));
            end
            // Long receiver hold-off while this phase's beats are still coming
            if (phase == 2)
                long_hold_arm = 1'b1;
            phase++;
        end

        wait_quiet();
        $display("Run covered %0d point writes and %0d samples, %0d past the table.",
                 points_taken, samples_taken, past_seen);
        $display("%0d results checked, %0d register writes, %0d phases, %0d-cycle hold-off.",
                 results_checked, reg_writes, phase, HOLD_OFF_CYCLES);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog, several times the slowest legal run
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

endmodule
